[rtl/ppit_pkg.sv]
// Shared constants, types and helpers for the polygon point inside test.
package ppit_pkg;

  localparam int COORD_BITS   = 16;
  localparam int MARGIN_BITS  = 11;
  localparam int OUT_CNT_BITS = 7;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;
  localparam int MAX_VERTICES = 64;

  localparam int EXT_BITS   = COORD_BITS + 1;
  localparam int DIFF_BITS  = COORD_BITS + 2;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;

  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = MARGIN_BITS'(13);
  localparam logic [COORD_BITS-1:0]  COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  localparam logic [0:0] REG_MARGIN = 1'b0;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_FEW  = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [EXT_BITS-1:0]   ext_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic rd_en;
    logic rd_last;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       query_ok;
    logic       busy;
  } sts_t;

  function automatic ext_t cext(coord_t v);
    return {v[COORD_BITS-1], v};
  endfunction

  function automatic diff_t dext(ext_t v);
    return {v[EXT_BITS-1], v};
  endfunction

  function automatic ext_t emin(ext_t a, ext_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic ext_t emax(ext_t a, ext_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

[rtl/ppit_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ppit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/ppit_ctrl.sv]
// Controller state machine: item intake, vertex read sequence, result handoff.
module ppit_ctrl #(
  parameter int MAX_VERTICES = ppit_pkg::MAX_VERTICES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  output logic                              result_valid,
  input  logic                              result_stall,
  input  ppit_pkg::sts_t                    sts,
  input  logic [$clog2(MAX_VERTICES+1)-1:0] total,
  output ppit_pkg::cmd_t                    cmd,
  output logic [$clog2(MAX_VERTICES)-1:0]   rd_addr
);

  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AW = $clog2(MAX_VERTICES);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [AW-1:0] idx;
  logic [AW-1:0] idx_next;
  logic [CW-1:0] total_m1;
  logic [AW-1:0] last_idx;

  assign total_m1   = total - CW'(1);
  assign last_idx   = total_m1[AW-1:0];
  assign item_stall = (state != S_IDLE);
  assign rd_addr    = idx;

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        idx_next = '0;
        if (sts.act == ppit_pkg::ACT_QUERY && sts.query_ok) begin
          state_next = S_READ;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        if (idx == last_idx) begin
          cmd.rd_last = 1'b1;
          state_next  = S_DRAIN;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      S_DRAIN: begin
        if (!sts.busy) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!result_valid || !result_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  ast_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(result_valid && result_stall))
    else $error("result overwritten while stalled");

  ast_idle_drained: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !sts.busy)
    else $error("edge pipeline busy while idle");

  ast_read_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (rd_addr <= last_idx && total >= CW'(3)))
    else $error("vertex read beyond stored polygon");

endmodule

[rtl/ppit_dp.sv]
// Datapath: vertex store, bounding box corner, edge test pipeline and result registers.
module ppit_dp #(
  parameter int MAX_VERTICES = ppit_pkg::MAX_VERTICES
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  ppit_pkg::cmd_t                          cmd,
  input  logic [$clog2(MAX_VERTICES)-1:0]         rd_addr,
  input  logic [1:0]                              action,
  input  ppit_pkg::coord_t                        point_x,
  input  ppit_pkg::coord_t                        point_y,
  input  logic [ppit_pkg::MARGIN_BITS-1:0]        margin,
  output ppit_pkg::sts_t                          sts,
  output logic [$clog2(MAX_VERTICES+1)-1:0]       total,
  output logic                                    is_inside,
  output logic [ppit_pkg::OUT_CNT_BITS-1:0]       crossing_count,
  output logic [ppit_pkg::OUT_CNT_BITS-1:0]       stored_vertices,
  output logic [1:0]                              status
);

  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CB = ppit_pkg::COORD_BITS;
  localparam int OB = ppit_pkg::OUT_CNT_BITS;

  logic [1:0]       act_q;
  ppit_pkg::ext_t   px, py, ex, ey;
  ppit_pkg::coord_t box_min_x, box_min_y;
  logic             full;
  logic [1:0]       res_status;
  logic [CW-1:0]    count;

  logic             ram_we;
  logic [2*CB-1:0]  ram_rdata;
  ppit_pkg::coord_t q_x, q_y;
  ppit_pkg::coord_t first_x, first_y, prev_x, prev_y;
  logic             need_first, rd_valid, rd_last_d, close_pend;

  logic             e_valid;
  ppit_pkg::coord_t e_ax, e_ay, e_bx, e_by;

  logic             v1, v2, v3, v4;
  ppit_pkg::ext_t   ax, ay, bx, by;
  ppit_pkg::diff_t  d2 [12];
  logic             box2, box3, box4;
  ppit_pkg::prod_t  m3 [8];
  logic [3:0]       pos4, neg4;
  logic             box_hit;
  ppit_pkg::cross_t cr [4];
  logic             hit;

  logic [CW+OB-1:0] count_w;
  logic [CW+OB-1:0] total_w;

  assign full         = (total == CW'(MAX_VERTICES));
  assign sts.act      = act_q;
  assign sts.query_ok = (total >= CW'(3));
  assign sts.busy     = rd_valid | close_pend | v1 | v2 | v3 | v4;
  assign ram_we       = cmd.exec && act_q == ppit_pkg::ACT_ADD && !full;
  assign q_x          = ram_rdata[CB-1:0];
  assign q_y          = ram_rdata[2*CB-1:CB];
  assign count_w      = {{OB{1'b0}}, count};
  assign total_w      = {{OB{1'b0}}, total};

  ppit_ram #(
    .WIDTH (2 * CB),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (total[AW-1:0]),
    .wdata ({py[CB-1:0], px[CB-1:0]}),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    e_valid = 1'b0;
    e_ax    = prev_x;
    e_ay    = prev_y;
    e_bx    = q_x;
    e_by    = q_y;
    if (close_pend) begin
      e_valid = 1'b1;
      e_bx    = first_x;
      e_by    = first_y;
    end else if (rd_valid && !need_first) begin
      e_valid = 1'b1;
    end
  end

  assign box_hit =
    (ppit_pkg::emin(ax, bx) <= ppit_pkg::emax(px, ex)) &&
    (ppit_pkg::emin(px, ex) <= ppit_pkg::emax(ax, bx)) &&
    (ppit_pkg::emin(ay, by) <= ppit_pkg::emax(py, ey)) &&
    (ppit_pkg::emin(py, ey) <= ppit_pkg::emax(ay, by));

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cr[k] = ppit_pkg::cross_t'(m3[2*k]) - ppit_pkg::cross_t'(m3[2*k+1]);
    end
  end

  assign hit = ((pos4 | neg4) == 4'b0000) ? box4 :
               (!((pos4[0] & pos4[1]) | (neg4[0] & neg4[1])) &&
                !((pos4[2] & pos4[3]) | (neg4[2] & neg4[3])));

  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= '0;
      box_min_x  <= ppit_pkg::COORD_MAX;
      box_min_y  <= ppit_pkg::COORD_MAX;
      count      <= '0;
      need_first <= 1'b1;
      rd_valid   <= 1'b0;
      rd_last_d  <= 1'b0;
      close_pend <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      v4         <= 1'b0;
    end else begin
      rd_valid  <= cmd.rd_en;
      rd_last_d <= cmd.rd_last;
      v1        <= e_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      if (close_pend) begin
        close_pend <= 1'b0;
      end else if (rd_valid && rd_last_d) begin
        close_pend <= 1'b1;
      end
      if (rd_valid && need_first) begin
        need_first <= 1'b0;
      end
      if (v4 && hit) begin
        count <= count + CW'(1);
      end
      if (cmd.exec) begin
        count      <= '0;
        need_first <= 1'b1;
        unique case (act_q)
          ppit_pkg::ACT_CLEAR: begin
            total     <= '0;
            box_min_x <= ppit_pkg::COORD_MAX;
            box_min_y <= ppit_pkg::COORD_MAX;
          end
          ppit_pkg::ACT_ADD: begin
            if (!full) begin
              total <= total + CW'(1);
              if (px < ppit_pkg::cext(box_min_x)) begin
                box_min_x <= px[CB-1:0];
              end
              if (py < ppit_pkg::cext(box_min_y)) begin
                box_min_y <= py[CB-1:0];
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_q <= action;
      px    <= ppit_pkg::cext(point_x);
      py    <= ppit_pkg::cext(point_y);
    end
    if (cmd.exec) begin
      ex <= ppit_pkg::cext(box_min_x) -
            ppit_pkg::ext_t'({{(ppit_pkg::EXT_BITS-ppit_pkg::MARGIN_BITS){1'b0}}, margin});
      ey <= ppit_pkg::cext(box_min_y) -
            ppit_pkg::ext_t'({{(ppit_pkg::EXT_BITS-ppit_pkg::MARGIN_BITS){1'b0}}, margin});
      unique case (act_q)
        ppit_pkg::ACT_ADD:   res_status <= full ? ppit_pkg::ST_FULL : ppit_pkg::ST_OK;
        ppit_pkg::ACT_QUERY: res_status <= sts.query_ok ? ppit_pkg::ST_OK : ppit_pkg::ST_FEW;
        default:             res_status <= ppit_pkg::ST_OK;
      endcase
    end
    if (rd_valid) begin
      prev_x <= q_x;
      prev_y <= q_y;
      if (need_first) begin
        first_x <= q_x;
        first_y <= q_y;
      end
    end
    ax <= ppit_pkg::cext(e_ax);
    ay <= ppit_pkg::cext(e_ay);
    bx <= ppit_pkg::cext(e_bx);
    by <= ppit_pkg::cext(e_by);

    d2[0]  <= ppit_pkg::dext(ex) - ppit_pkg::dext(px);
    d2[1]  <= ppit_pkg::dext(ey) - ppit_pkg::dext(py);
    d2[2]  <= ppit_pkg::dext(ax) - ppit_pkg::dext(px);
    d2[3]  <= ppit_pkg::dext(ay) - ppit_pkg::dext(py);
    d2[4]  <= ppit_pkg::dext(bx) - ppit_pkg::dext(px);
    d2[5]  <= ppit_pkg::dext(by) - ppit_pkg::dext(py);
    d2[6]  <= ppit_pkg::dext(bx) - ppit_pkg::dext(ax);
    d2[7]  <= ppit_pkg::dext(by) - ppit_pkg::dext(ay);
    d2[8]  <= ppit_pkg::dext(px) - ppit_pkg::dext(ax);
    d2[9]  <= ppit_pkg::dext(py) - ppit_pkg::dext(ay);
    d2[10] <= ppit_pkg::dext(ex) - ppit_pkg::dext(ax);
    d2[11] <= ppit_pkg::dext(ey) - ppit_pkg::dext(ay);
    box2   <= box_hit;

    m3[0] <= ppit_pkg::prod_t'(d2[0]) * ppit_pkg::prod_t'(d2[3]);
    m3[1] <= ppit_pkg::prod_t'(d2[1]) * ppit_pkg::prod_t'(d2[2]);
    m3[2] <= ppit_pkg::prod_t'(d2[0]) * ppit_pkg::prod_t'(d2[5]);
    m3[3] <= ppit_pkg::prod_t'(d2[1]) * ppit_pkg::prod_t'(d2[4]);
    m3[4] <= ppit_pkg::prod_t'(d2[6]) * ppit_pkg::prod_t'(d2[9]);
    m3[5] <= ppit_pkg::prod_t'(d2[7]) * ppit_pkg::prod_t'(d2[8]);
    m3[6] <= ppit_pkg::prod_t'(d2[6]) * ppit_pkg::prod_t'(d2[11]);
    m3[7] <= ppit_pkg::prod_t'(d2[7]) * ppit_pkg::prod_t'(d2[10]);
    box3  <= box2;

    for (int k = 0; k < 4; k++) begin
      neg4[k] <= cr[k][ppit_pkg::CROSS_BITS-1];
      pos4[k] <= !cr[k][ppit_pkg::CROSS_BITS-1] && (cr[k] != '0);
    end
    box4 <= box3;

    if (cmd.out_load) begin
      is_inside       <= count[0];
      crossing_count  <= count_w[OB-1:0];
      stored_vertices <= total_w[OB-1:0];
      status          <= res_status;
    end
  end

  ast_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(MAX_VERTICES))
    else $error("vertex total above store depth");

  ast_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= total)
    else $error("crossing count above vertex total");

endmodule

[rtl/polygon_point_inside_test.sv]
// Top level of the polygon point inside test: configuration port, controller, datapath.
//
// Input channel (item_valid / item_stall) carries action, point_x, point_y.
// action clear empties the polygon, add appends a vertex, query tests a point.
// Output channel (result_valid / result_stall) returns one result per item:
// is_inside, crossing_count, stored_vertices and status.
// Clear, add and unused actions go from execute straight to the result state.
// A query on n stored vertices reads the vertex store one entry per cycle, and each
// edge goes through an orientation pipeline with one 18x18 multiplier per product.
// One item is worked on at a time; the next item is taken as soon as the
// result sits in the output register, even while the receiver stalls it.
// A stalled result holds; the block then finishes its current item and waits.
// The user writes exterior_margin (APB address 0) only while idle; nothing enforces it.
// Reset empties the polygon, sets the box corner to the most positive
// coordinate and the margin to 13; vertex entries are undefined until added.
module polygon_point_inside_test #(
  parameter int MAX_VERTICES = ppit_pkg::MAX_VERTICES
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic [1:0]                            action,
  input  logic signed [ppit_pkg::COORD_BITS-1:0] point_x,
  input  logic signed [ppit_pkg::COORD_BITS-1:0] point_y,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic                                  is_inside,
  output logic [ppit_pkg::OUT_CNT_BITS-1:0]     crossing_count,
  output logic [ppit_pkg::OUT_CNT_BITS-1:0]     stored_vertices,
  output logic [1:0]                            status,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ppit_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [ppit_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [ppit_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                  pready
);

  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AW = $clog2(MAX_VERTICES);

  logic [ppit_pkg::MARGIN_BITS-1:0] margin;
  logic                             reg_sel;
  ppit_pkg::cmd_t                   cmd;
  ppit_pkg::sts_t                   sts;
  logic [CW-1:0]                    total;
  logic [AW-1:0]                    rd_addr;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == ppit_pkg::REG_MARGIN);
  assign prdata  = reg_sel ?
    {{(ppit_pkg::APB_DATA_BITS-ppit_pkg::MARGIN_BITS){1'b0}}, margin} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      margin <= ppit_pkg::MARGIN_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      margin <= pwdata[ppit_pkg::MARGIN_BITS-1:0];
    end
  end

  ppit_ctrl #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .total        (total),
    .cmd          (cmd),
    .rd_addr      (rd_addr)
  );

  ppit_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .rd_addr         (rd_addr),
    .action          (action),
    .point_x         (point_x),
    .point_y         (point_y),
    .margin          (margin),
    .sts             (sts),
    .total           (total),
    .is_inside       (is_inside),
    .crossing_count  (crossing_count),
    .stored_vertices (stored_vertices),
    .status          (status)
  );

endmodule
